### rtl/brd_pkg.sv
// Shared types and codes for the byte ring deque.
`default_nettype none

package brd_pkg;

   // Fixed field widths of the stream payload
   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;
   localparam int RUN_W  = 7;   // holds a run length up to 64

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   // Commands
   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PREPEND   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DROP_HEAD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DROP_TAIL = 3'd4;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_DATA  = 2'd2;
   localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

   // Job kinds handed from front to back
   typedef logic [1:0] brd_kind_type;
   localparam brd_kind_type JOB_REPLY = 2'd0;  // one result, no store access
   localparam brd_kind_type JOB_WRITE = 2'd1;  // one result, store one byte
   localparam brd_kind_type JOB_READ  = 2'd2;  // run of results read from store

   typedef struct packed {
      brd_kind_type       kind;
      logic [STAT_W-1:0]  status;
      logic [BYTE_W-1:0]  data;
      logic [RUN_W-1:0]   run_len;
      logic [CNT_W-1:0]   used;
      logic [CNT_W-1:0]   free;
   } brd_job_type;

endpackage

`default_nettype wire

### rtl/brd_queue.sv
// Short first-in first-out queue of jobs between front and back.
`default_nettype none

module brd_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data,
   output logic              pop_valid
);
   import brd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [W-1:0]  entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;

   assign full      = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/brd_front.sv
// Front end: takes items, checks space, moves head and tail, emits jobs.
`default_nettype none

module brd_front #(
   parameter int DEPTH      = 1024,
   parameter int MAX_REMOVE = 64,
   parameter int IW         = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [brd_pkg::CMD_W-1:0]   command,
   input  wire logic [brd_pkg::BYTE_W-1:0]  data,
   input  wire logic                        burst_first,
   input  wire logic [brd_pkg::CNT_W-1:0]   count,
   input  wire logic                        queue_full,
   output logic                             job_push,
   output brd_pkg::brd_job_type             job,
   output logic [IW-1:0]                    job_addr
);
   import brd_pkg::*;

   localparam int UW = $clog2(DEPTH + 1);
   localparam int SW = UW + 1;
   localparam int CW = (UW > CNT_W) ? UW : CNT_W;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [UW-1:0] DEPTH_U = UW'(DEPTH);
   localparam logic [CW-1:0] MAX_REM_C = CW'(MAX_REMOVE);

   // (idx + n) mod DEPTH for n in 0..DEPTH
   function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] idx,
                                             input logic [UW-1:0] n);
      logic [SW-1:0] s;
      s = SW'(idx) + SW'(n);
      if (s >= DEPTH_S) s = s - DEPTH_S;
      return s[IW-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] mask11(input logic [UW-1:0] v);
      logic [CW-1:0] t;
      t = CW'(v);
      return t[CNT_W-1:0];
   endfunction

   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [IW-1:0]    burst_wr_ff, burst_wr_in;
   logic [CNT_W-1:0] burst_left_ff, burst_left_in;
   logic             burst_rej_ff, burst_rej_in;

   logic [CW-1:0]    cnt_w, used_w, free_w, blen, blen_m1;
   logic [IW-1:0]    wr_at;
   logic             accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign job_push = accept;

   // Classify the item and work out the next pointer state
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      burst_wr_in   = burst_wr_ff;
      burst_left_in = burst_left_ff;
      burst_rej_in  = burst_rej_ff;
      job           = '0;
      job.kind      = JOB_REPLY;
      job.status    = ST_OK;
      job.data      = data;
      job_addr      = head_ff;
      wr_at         = '0;
      cnt_w         = CW'(count);
      used_w        = CW'(used_ff);
      free_w        = CW'(DEPTH_U - used_ff);
      blen          = (!burst_first || count == '0) ? CW'(1) : cnt_w;
      blen_m1       = blen - 1'b1;

      unique case (command)
         CMD_APPEND, CMD_PREPEND: begin
            if (burst_first || burst_left_ff == '0) begin
               // first byte: reserve the whole burst or reject it
               burst_left_in = blen_m1[CNT_W-1:0];
               if (blen > free_w) begin
                  burst_rej_in = 1'b1;
                  job.status   = ST_NO_SPACE;
               end else begin
                  burst_rej_in = 1'b0;
                  used_in      = used_ff + blen[UW-1:0];
                  if (command == CMD_APPEND) begin
                     wr_at   = tail_ff;
                     tail_in = add_mod(tail_ff, blen[UW-1:0]);
                  end else begin
                     wr_at   = add_mod(head_ff, DEPTH_U - blen[UW-1:0]);
                     head_in = wr_at;
                  end
                  job.kind    = JOB_WRITE;
                  job_addr    = wr_at;
                  burst_wr_in = add_mod(wr_at, UW'(1));
               end
            end else begin
               // later byte of a pending burst
               burst_left_in = burst_left_ff - 1'b1;
               if (burst_rej_ff) begin
                  job.status = ST_NO_SPACE;
                  if (burst_left_ff == CNT_W'(1)) burst_rej_in = 1'b0;
               end else begin
                  job.kind    = JOB_WRITE;
                  job_addr    = burst_wr_ff;
                  burst_wr_in = add_mod(burst_wr_ff, UW'(1));
               end
            end
         end
         CMD_REMOVE: begin
            priority if (cnt_w > MAX_REM_C) begin
               job.status = ST_TOO_LONG;
            end else if (cnt_w > used_w) begin
               job.status = ST_NO_DATA;
            end else if (count == '0) begin
               job.status = ST_OK;
            end else begin
               job.kind    = JOB_READ;
               job.run_len = cnt_w[RUN_W-1:0];
               job_addr    = head_ff;
               head_in     = add_mod(head_ff, cnt_w[UW-1:0]);
               used_in     = used_ff - cnt_w[UW-1:0];
            end
         end
         CMD_DROP_HEAD, CMD_DROP_TAIL: begin
            if (cnt_w > used_w) begin
               job.status = ST_NO_DATA;
            end else begin
               used_in = used_ff - cnt_w[UW-1:0];
               if (command == CMD_DROP_HEAD) begin
                  head_in = add_mod(head_ff, cnt_w[UW-1:0]);
               end else begin
                  tail_in = add_mod(tail_ff, DEPTH_U - cnt_w[UW-1:0]);
               end
            end
         end
         default: begin
            job.status = ST_OK;
         end
      endcase

      job.used = mask11(used_in);
      job.free = mask11(DEPTH_U - used_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         used_ff       <= '0;
         burst_wr_ff   <= '0;
         burst_left_ff <= '0;
         burst_rej_ff  <= 1'b0;
      end else if (accept) begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         used_ff       <= used_in;
         burst_wr_ff   <= burst_wr_in;
         burst_left_ff <= burst_left_in;
         burst_rej_ff  <= burst_rej_in;
      end
   end

endmodule

`default_nettype wire

### rtl/brd_back.sv
// Back end: byte store, run sequencer and registered result stage.
`default_nettype none

module brd_back #(
   parameter int DEPTH = 1024,
   parameter int IW    = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_valid,
   input  wire brd_pkg::brd_job_type        job,
   input  wire logic [IW-1:0]               job_addr,
   output logic                             job_pop,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [brd_pkg::STAT_W-1:0]       out_status,
   output logic [brd_pkg::BYTE_W-1:0]       out_data,
   output logic                             out_last,
   output logic [brd_pkg::CNT_W-1:0]        out_used,
   output logic [brd_pkg::CNT_W-1:0]        out_free
);
   import brd_pkg::*;

   function automatic logic [IW-1:0] inc_mod(input logic [IW-1:0] idx);
      return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_q_ff;

   // run sequencer
   logic              run_act_ff;
   logic [IW-1:0]     run_addr_ff;
   logic [RUN_W-1:0]  run_left_ff;

   // read stage
   logic              a_valid_ff, a_read_ff, a_last_ff;
   logic [STAT_W-1:0] a_status_ff;
   logic [CNT_W-1:0]  a_used_ff, a_free_ff;

   // result register
   logic              o_valid_ff, o_last_ff;
   logic [STAT_W-1:0] o_status_ff;
   logic [BYTE_W-1:0] o_data_ff;
   logic [CNT_W-1:0]  o_used_ff, o_free_ff;

   logic              advance, issue, is_read, run_end;
   logic [IW-1:0]     cur_addr;
   logic [RUN_W-1:0]  cur_left;

   // Issue control: one store access per cycle while the result side moves
   always_comb begin
      advance  = !o_valid_ff || out_ready;
      issue    = job_valid && advance;
      is_read  = (job.kind == JOB_READ);
      cur_addr = run_act_ff ? run_addr_ff : job_addr;
      cur_left = run_act_ff ? run_left_ff : job.run_len;
      run_end  = !is_read || (cur_left == RUN_W'(1));
      job_pop  = issue && run_end;
   end

   // Byte store
   always_ff @(posedge clock) begin
      if (issue && job.kind == JOB_WRITE) begin
         store_mem[cur_addr] <= job.data;
      end
      if (issue && is_read) begin
         rd_q_ff <= store_mem[cur_addr];
      end
   end

   // Run sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         run_act_ff <= 1'b0;
      end else if (issue && is_read) begin
         run_act_ff <= !run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (issue && is_read) begin
         run_addr_ff <= inc_mod(cur_addr);
         run_left_ff <= cur_left - 1'b1;
      end
   end

   // Read stage and result register valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= job_valid;
         o_valid_ff <= a_valid_ff;
      end
   end

   // Read stage and result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_read_ff   <= is_read;
         a_last_ff   <= run_end;
         a_status_ff <= job.status;
         a_used_ff   <= job.used;
         a_free_ff   <= job.free;
         o_last_ff   <= a_last_ff;
         o_status_ff <= a_status_ff;
         o_data_ff   <= a_read_ff ? rd_q_ff : '0;
         o_used_ff   <= a_used_ff;
         o_free_ff   <= a_free_ff;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_status = o_status_ff;
   assign out_data   = o_data_ff;
   assign out_last   = o_last_ff;
   assign out_used   = o_used_ff;
   assign out_free   = o_free_ff;

endmodule

`default_nettype wire

### rtl/byte_ring_deque.sv
// Top level of the byte ring deque: front end, job queue and back end.
`default_nettype none

// Byte ring deque over a DEPTH-entry byte store. Commands arrive on the req
// stream: append and prepend bursts (reserved whole on their first byte),
// remove runs of up to MAX_REMOVE bytes from the head, and drops from the
// head or tail. The front end takes one item per cycle while the job queue
// has room and updates the pointers at once; a four-entry job queue feeds
// the back end, which gives one result per cycle on the rsp stream while
// rsp_tready is high, through a single store port. A remove run of n bytes
// gives n results, every other item one; results pass the job queue, read
// stage and result register. The store needs no clearing after reset.
module byte_ring_deque #(
   parameter int DEPTH      = 1024,
   parameter int MAX_REMOVE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // command[2:0], data[10:3], count[21:11]
   input  wire logic        req_tuser,  // burst_first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // status[1:0], data_out[9:2], used[20:10], free[31:21]
   output logic             rsp_tlast
);
   import brd_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int QW = IW + $bits(brd_job_type);

   logic              q_full, f_push, q_pop, q_valid;
   brd_job_type       f_job, q_job;
   logic [IW-1:0]     f_addr, q_addr;
   logic [QW-1:0]     q_in, q_out;
   logic [STAT_W-1:0] r_status;
   logic [BYTE_W-1:0] r_data;
   logic [CNT_W-1:0]  r_used, r_free;

   brd_front #(
      .DEPTH      (DEPTH),
      .MAX_REMOVE (MAX_REMOVE),
      .IW         (IW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .command     (req_tdata[2:0]),
      .data        (req_tdata[10:3]),
      .burst_first (req_tuser),
      .count       (req_tdata[21:11]),
      .queue_full  (q_full),
      .job_push    (f_push),
      .job         (f_job),
      .job_addr    (f_addr)
   );

   assign q_in   = {f_addr, f_job};
   assign q_addr = q_out[QW-1:QW-IW];
   assign q_job  = q_out[QW-IW-1:0];

   brd_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .pop_valid (q_valid)
   );

   brd_back #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job        (q_job),
      .job_addr   (q_addr),
      .job_pop    (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (r_status),
      .out_data   (r_data),
      .out_last   (rsp_tlast),
      .out_used   (r_used),
      .out_free   (r_free)
   );

   assign rsp_tdata = {r_free, r_used, r_data, r_status};

endmodule

`default_nettype wire

### rtl/brd_checker.sv
// Port-level checks for the byte ring deque and their bind.
`default_nettype none

module brd_checker #(
   parameter int DEPTH = 1024
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   import brd_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_M = CNT_W'(DEPTH);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // used plus free always fills the store
   a_fill_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> CNT_W'(rsp_tdata[20:10] + rsp_tdata[31:21]) == DEPTH_M)
      else $error("used and free do not add up");

   // error results carry no byte and end their item
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[9:2] == '0 && rsp_tlast)
      else $error("error result with data or without last");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind byte_ring_deque brd_checker #(.DEPTH(DEPTH)) u_brd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the byte ring deque: scripted and random command streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import brd_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int MAX_REMOVE   = 64;
   localparam int IDLE_PCT     = 29;
   localparam int RANDOM_ITEMS = 435;
   localparam int SCRIPT_LEN   = 25;
   localparam int HOLD_AT      = SCRIPT_LEN + 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_LO      = SCRIPT_LEN + 260;
   localparam int CALM_HI      = CALM_LO + 80;
   localparam int DRAIN_CYCLES = 32;
   localparam int REPORT_LIMIT = 10;
   localparam int CYCLE_LIMIT  = 1500000;

   // command codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_DROP_TAIL + 1'b1;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

   // one result as it travels on the rsp stream
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [CNT_W-1:0]  used;
      logic [CNT_W-1:0]  free;
   } ring_result_type;

   // scripted command; typed rows carry their single expected result
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] dat;
      logic              first;
      logic [CNT_W-1:0]  cnt;
      logic              typed;
      logic [STAT_W-1:0] st;
      logic [CNT_W-1:0]  used;
   } script_row_type;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // empty ring: errors, zero counts, no-op command
      '{CMD_REMOVE,    8'h00, 1'b1, 11'd1,    1'b1, ST_NO_DATA,  11'd0},
      '{CMD_DROP_TAIL, 8'h00, 1'b1, 11'd0,    1'b1, ST_OK,       11'd0},
      '{CMD_REMOVE,    8'h00, 1'b1, 11'd0,    1'b1, ST_OK,       11'd0},
      '{CMD_REMOVE,    8'h00, 1'b1, 11'd65,   1'b1, ST_TOO_LONG, 11'd0},
      '{CMD_SPARE_HI,  8'hFF, 1'b1, 11'd2047, 1'b1, ST_OK,       11'd0},
      // oversize burst is rejected and eats its follow-on byte
      '{CMD_APPEND,    8'h00, 1'b1, 11'd2047, 1'b1, ST_NO_SPACE, 11'd0},
      '{CMD_APPEND,    8'h5A, 1'b0, 11'd0,    1'b1, ST_NO_SPACE, 11'd0},
      '{CMD_PREPEND,   8'hA5, 1'b1, 11'd1025, 1'b1, ST_NO_SPACE, 11'd0},
      // zero-length burst, then an unmarked byte with nothing pending
      '{CMD_APPEND,    8'h00, 1'b1, 11'd0,    1'b1, ST_OK,       11'd1},
      '{CMD_APPEND,    8'hFF, 1'b0, 11'd5,    1'b1, ST_OK,       11'd2},
      // prepend across zero with a remove in the middle of the burst
      '{CMD_PREPEND,   8'hA5, 1'b1, 11'd3,    1'b0, ST_OK,       11'd0},
      '{CMD_PREPEND,   8'h5A, 1'b0, 11'd0,    1'b0, ST_OK,       11'd0},
      '{CMD_REMOVE,    8'h00, 1'b0, 11'd2,    1'b0, ST_OK,       11'd0},
      '{CMD_PREPEND,   8'h3C, 1'b0, 11'd0,    1'b0, ST_OK,       11'd0},
      '{CMD_REMOVE,    8'h00, 1'b0, 11'd3,    1'b0, ST_OK,       11'd0},
      // full ring from one reservation, then a new burst abandons it
      '{CMD_PREPEND,   8'h11, 1'b1, 11'd1024, 1'b1, ST_OK,       11'd1024},
      '{CMD_APPEND,    8'h22, 1'b1, 11'd1,    1'b1, ST_NO_SPACE, 11'd1024},
      '{CMD_DROP_TAIL, 8'h00, 1'b0, 11'd1025, 1'b1, ST_NO_DATA,  11'd1024},
      '{CMD_DROP_HEAD, 8'h00, 1'b0, 11'd1023, 1'b1, ST_OK,       11'd1},
      '{CMD_REMOVE,    8'h00, 1'b0, 11'd1,    1'b0, ST_OK,       11'd0},
      '{CMD_APPEND,    8'h80, 1'b1, 11'd2,    1'b0, ST_OK,       11'd0},
      '{CMD_APPEND,    8'h7F, 1'b0, 11'd0,    1'b0, ST_OK,       11'd0},
      '{CMD_REMOVE,    8'h00, 1'b0, 11'd2,    1'b0, ST_OK,       11'd0},
      // fill completely and empty with one tail drop
      '{CMD_PREPEND,   8'h00, 1'b1, 11'd1024, 1'b1, ST_OK,       11'd1024},
      '{CMD_DROP_TAIL, 8'h00, 1'b0, 11'd1024, 1'b1, ST_OK,       11'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // command[2:0], data[10:3], count[21:11]
   logic        req_tuser  = 1'b0; // burst_first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // status[1:0], data_out[9:2], used[20:10], free[31:21]
   logic        rsp_tlast;

   // ring model state
   logic [BYTE_W-1:0] ring_mem [DEPTH];
   bit                ring_written [DEPTH];
   int unsigned       ring_head  = 0;
   int unsigned       ring_tail  = 0;
   bit                ring_full  = 1'b0;
   int unsigned       burst_ptr  = 0;
   int unsigned       burst_left = 0;
   bit                burst_bad  = 1'b0;

   ring_result_type   pending_results[$];
   int unsigned       mismatch_count = 0;
   int unsigned       items_sent     = 0;
   int unsigned       cycle_count    = 0;
   bit                hold_active    = 1'b0;
   bit                hold_done      = 1'b0;

   // random burst in flight on the stimulus side
   int unsigned       plan_left = 0;
   logic [CMD_W-1:0]  plan_cmd  = CMD_APPEND;

   byte_ring_deque #(
      .DEPTH(DEPTH),
      .MAX_REMOVE(MAX_REMOVE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic int unsigned ring_used();
      if (ring_head == ring_tail) return ring_full ? DEPTH : 0;
      return (ring_tail + DEPTH - ring_head) % DEPTH;
   endfunction

   // full flag only matters when the pointers meet
   function automatic void move_ptrs(int unsigned h, int unsigned t, int unsigned held);
      ring_head = h % DEPTH;
      ring_tail = t % DEPTH;
      ring_full = (ring_head == ring_tail) && (held >= DEPTH);
   endfunction

   function automatic void store_byte(logic [BYTE_W-1:0] dat);
      ring_mem[burst_ptr]     = dat;
      ring_written[burst_ptr] = 1'b1;
      burst_ptr               = (burst_ptr + 1) % DEPTH;
   endfunction

   // bytes from the head that may be removed without touching a never-written slot
   function automatic int unsigned safe_run();
      int unsigned lim;
      int unsigned k;
      lim = (ring_used() < MAX_REMOVE) ? ring_used() : MAX_REMOVE;
      for (k = 0; k < lim; k++)
         if (!ring_written[(ring_head + k) % DEPTH]) break;
      return k;
   endfunction

   function automatic ring_result_type make_result(logic [STAT_W-1:0] st,
                                                   logic [BYTE_W-1:0] dat,
                                                   logic last_flag, int unsigned held);
      ring_result_type r;
      r.status = st;
      r.data   = dat;
      r.last   = last_flag;
      r.used   = CNT_W'(held);
      r.free   = CNT_W'(DEPTH - held);
      return r;
   endfunction

   // advance the ring model by one accepted command, queue the results it gives
   function automatic void predict_ring_step(input logic [CMD_W-1:0] cmd,
                                             input logic [BYTE_W-1:0] dat,
                                             input logic first, input logic [CNT_W-1:0] cnt,
                                             ref ring_result_type out[$]);
      int unsigned       used;
      int unsigned       c;
      int unsigned       new_head;
      logic [BYTE_W-1:0] run_bytes[$];
      logic              opens;
      used  = ring_used();
      c     = cnt;
      opens = first;
      case (cmd)
         CMD_APPEND, CMD_PREPEND: begin
            // unmarked byte with nothing pending is a burst of one
            if (!opens && burst_left == 0) begin
               opens = 1'b1;
               c     = 1;
            end
            if (opens) begin
               if (c == 0) c = 1;
               burst_left = c - 1;
               burst_bad  = (c > DEPTH - used);
               if (burst_bad) begin
                  out.push_back(make_result(ST_NO_SPACE, '0, 1'b1, used));
               end else begin
                  // whole burst reserved now; prepend moves the head back first
                  if (cmd == CMD_APPEND) begin
                     burst_ptr = ring_tail;
                     move_ptrs(ring_head, ring_tail + c, used + c);
                  end else begin
                     new_head  = (ring_head + DEPTH - c % DEPTH) % DEPTH;
                     burst_ptr = new_head;
                     move_ptrs(new_head, ring_tail, used + c);
                  end
                  store_byte(dat);
                  out.push_back(make_result(ST_OK, '0, 1'b1, ring_used()));
               end
            end else begin
               burst_left--;
               if (burst_bad) begin
                  if (burst_left == 0) burst_bad = 1'b0;
                  out.push_back(make_result(ST_NO_SPACE, '0, 1'b1, used));
               end else begin
                  store_byte(dat);
                  out.push_back(make_result(ST_OK, '0, 1'b1, used));
               end
            end
         end
         CMD_REMOVE: begin
            if (c > MAX_REMOVE) begin
               out.push_back(make_result(ST_TOO_LONG, '0, 1'b1, used));
            end else if (c > used) begin
               out.push_back(make_result(ST_NO_DATA, '0, 1'b1, used));
            end else if (c == 0) begin
               out.push_back(make_result(ST_OK, '0, 1'b1, used));
            end else begin
               for (int k = 0; k < c; k++)
                  run_bytes.push_back(ring_mem[(ring_head + k) % DEPTH]);
               move_ptrs(ring_head + c, ring_tail, used - c);
               for (int k = 0; k < c; k++)
                  out.push_back(make_result(ST_OK, run_bytes[k], k + 1 == c, ring_used()));
            end
         end
         CMD_DROP_HEAD, CMD_DROP_TAIL: begin
            if (c > used) begin
               out.push_back(make_result(ST_NO_DATA, '0, 1'b1, used));
            end else begin
               if (c != 0) begin
                  if (cmd == CMD_DROP_HEAD)
                     move_ptrs(ring_head + c, ring_tail, used - c);
                  else
                     move_ptrs(ring_head, ring_tail + DEPTH - c % DEPTH, used - c);
               end
               out.push_back(make_result(ST_OK, '0, 1'b1, ring_used()));
            end
         end
         default: begin
            out.push_back(make_result(ST_OK, '0, 1'b1, used));
         end
      endcase
   endfunction

   function automatic bit calm_window();
      return items_sent >= CALM_LO && items_sent < CALM_HI;
   endfunction

   // random command: mostly complete bursts and legal removes, some noise
   task automatic pick_random_item(output logic [CMD_W-1:0] cmd, output logic [BYTE_W-1:0] dat,
                                   output logic first, output logic [CNT_W-1:0] cnt);
      int unsigned used;
      int unsigned room;
      int unsigned roll;
      int unsigned n;
      int unsigned safe;
      used  = ring_used();
      room  = DEPTH - used;
      safe  = safe_run();
      dat   = BYTE_W'($urandom_range(0, 255));
      cnt   = CNT_W'($urandom_range(0, 2047));
      first = 1'b0;
      cmd   = plan_cmd;
      roll  = $urandom_range(0, 99);
      if (plan_left != 0 && roll < 88) begin
         plan_left--;
      end else begin
         roll = $urandom_range(0, 99);
         // nearly full: favor drops so bursts keep fitting
         if (used > 900 && roll < 40) roll = 70;
         if (roll < 40) begin
            cmd   = $urandom_range(0, 1) ? CMD_PREPEND : CMD_APPEND;
            first = 1'b1;
            roll  = $urandom_range(0, 99);
            if (roll < 80) begin
               n         = $urandom_range(1, 12);
               plan_left = n - 1;
            end else if (roll < 88) begin
               n         = (room == 0) ? 1 : room;
               plan_left = $urandom_range(0, 4);
            end else if (roll < 95) begin
               n         = room + $urandom_range(1, 50);
               plan_left = $urandom_range(0, 3);
            end else begin
               n         = 0;
               plan_left = 0;
            end
            if (n != 0 && plan_left > n - 1) plan_left = n - 1;
            plan_cmd = cmd;
            cnt      = CNT_W'(n);
         end else if (roll < 68) begin
            cmd = CMD_REMOVE;
            if ($urandom_range(0, 99) < 15)
               cnt = $urandom_range(0, 1) ? CNT_W'($urandom_range(used + 1, used + 64))
                                          : CNT_W'($urandom_range(MAX_REMOVE + 1, 2047));
            else
               cnt = (safe == 0) ? '0 : CNT_W'($urandom_range(1, safe));
         end else if (roll < 85) begin
            cmd = $urandom_range(0, 1) ? CMD_DROP_TAIL : CMD_DROP_HEAD;
            if ($urandom_range(0, 99) < 15)
               cnt = CNT_W'($urandom_range(used + 1, 2047));
            else
               cnt = CNT_W'($urandom_range(0, used));
         end else if (roll < 93) begin
            // unmarked byte outside the planned burst
            cmd = $urandom_range(0, 1) ? CMD_PREPEND : CMD_APPEND;
         end else begin
            cmd   = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            first = 1'($urandom_range(0, 1));
         end
      end
   endtask

   // offer one command and return at the edge where it transfers
   task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] dat,
                             input logic first, input logic [CNT_W-1:0] cnt);
      while (!calm_window() && !hold_active && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, cnt, dat, cmd};
      req_tuser  <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   // result side: random back-pressure, one long hold-off, a calm stretch
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done   = 1'b1;
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         rsp_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each result transfer with the oldest expectation
   task automatic check_result();
      ring_result_type want;
      ring_result_type seen;
      seen.status = rsp_tdata[1:0];
      seen.data   = rsp_tdata[9:2];
      seen.last   = rsp_tlast;
      seen.used   = rsp_tdata[20:10];
      seen.free   = rsp_tdata[31:21];
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: status %0d data %02h last %0b used %0d free %0d",
                     seen.status, seen.data, seen.last, seen.used, seen.free);
      end else begin
         want = pending_results.pop_front();
         if (want.status !== seen.status || want.data !== seen.data ||
             want.last !== seen.last || want.used !== seen.used || want.free !== seen.free) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result mismatch (exp/got): status %0d/%0d data %02h/%02h last %0b/%0b",
                        want.status, seen.status, want.data, seen.data, want.last, seen.last,
                        " used %0d/%0d free %0d/%0d",
                        want.used, seen.used, want.free, seen.free);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // main sequence
   initial begin
      ring_result_type   scratch[$];
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] dat;
      logic              first;
      logic [CNT_W-1:0]  cnt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // scripted corner cases
      foreach (SCRIPT[i]) begin
         offer_item(SCRIPT[i].cmd, SCRIPT[i].dat, SCRIPT[i].first, SCRIPT[i].cnt);
         if (SCRIPT[i].typed) begin
            predict_ring_step(SCRIPT[i].cmd, SCRIPT[i].dat, SCRIPT[i].first, SCRIPT[i].cnt,
                              scratch);
            scratch.delete();
            pending_results.push_back(make_result(SCRIPT[i].st, '0, 1'b1, SCRIPT[i].used));
         end else begin
            predict_ring_step(SCRIPT[i].cmd, SCRIPT[i].dat, SCRIPT[i].first, SCRIPT[i].cnt,
                              pending_results);
         end
      end

      // random traffic
      while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
         pick_random_item(cmd, dat, first, cnt);
         offer_item(cmd, dat, first, cnt);
         predict_ring_step(cmd, dat, first, cnt, pending_results);
      end
      req_tvalid <= 1'b0;

      // drain, then give stray results a chance to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
